>>> rtl/lru_cache_miss_counter_top_assert.svh
`ifndef LRU_CACHE_MISS_COUNTER_TOP_ASSERT_SVH
`define LRU_CACHE_MISS_COUNTER_TOP_ASSERT_SVH

// same-cycle implication
`define LCMC_ASSERT_NOW(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("lcmc assertion failed");

// next-cycle implication
`define LCMC_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("lcmc assertion failed");

`endif

>>> rtl/lcmc_pkg.sv
package lcmc_pkg;

  localparam int KEY_W = 32;
  localparam int CAP_W = 5;
  localparam int OCC_W = 5;
  localparam int MISS_W = 32;
  localparam int MAX_ENTRIES_DEFAULT = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic hit;
    logic evict;
    logic insert;
  } lcmc_ctrl_t;

endpackage

>>> rtl/lcmc_lookup.sv
module lcmc_lookup #(
  parameter int MAX_ENTRIES = lcmc_pkg::MAX_ENTRIES_DEFAULT,
  parameter int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  parameter int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic [lcmc_pkg::KEY_W-1:0] key,
  input  logic [lcmc_pkg::KEY_W-1:0] keys [MAX_ENTRIES],
  input  logic [RW-1:0]              ranks [MAX_ENTRIES],
  input  logic [CW-1:0]              count,
  input  logic [lcmc_pkg::CAP_W-1:0] capacity,
  output lcmc_pkg::lcmc_ctrl_t       ctrl,
  output logic [MAX_ENTRIES-1:0]     sel,
  output logic [RW-1:0]              sel_rank,
  output logic [lcmc_pkg::KEY_W-1:0] evicted_key,
  output logic [CW-1:0]              count_next
);
  import lcmc_pkg::*;

  logic [MAX_ENTRIES-1:0] occ;
  logic [MAX_ENTRIES-1:0] match;
  logic [MAX_ENTRIES-1:0] oldest;
  logic [31:0] cap32;
  logic [31:0] cap_eff;
  logic [RW-1:0] last_rank;
  logic full;

  always_comb begin
    cap32 = {{(32-CAP_W){1'b0}}, capacity};
    if (cap32 == 32'd0) begin
      cap_eff = 32'd1;
    end else if (cap32 > 32'(MAX_ENTRIES)) begin
      cap_eff = 32'(MAX_ENTRIES);
    end else begin
      cap_eff = cap32;
    end
    full = 32'(count) >= cap_eff;
    last_rank = RW'(count - CW'(1));
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      occ[i] = CW'(i) < count;
      match[i] = occ[i] && (keys[i] == key);
      oldest[i] = occ[i] && (ranks[i] == last_rank);
    end
    ctrl.hit = |match;
    ctrl.evict = !ctrl.hit && full;
    ctrl.insert = !ctrl.hit && !full;
    sel_rank = '0;
    evicted_key = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (ctrl.hit) begin
        sel[i] = match[i];
      end else if (ctrl.evict) begin
        sel[i] = oldest[i];
      end else begin
        sel[i] = CW'(i) == count;
      end
      if (sel[i]) begin
        sel_rank = sel_rank | ranks[i];
      end
      if (ctrl.evict && oldest[i]) begin
        evicted_key = evicted_key | keys[i];
      end
    end
    count_next = count + CW'(ctrl.insert);
  end

endmodule

>>> rtl/lcmc_store.sv
module lcmc_store #(
  parameter int MAX_ENTRIES = lcmc_pkg::MAX_ENTRIES_DEFAULT,
  parameter int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  parameter int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  logic [lcmc_pkg::KEY_W-1:0] key,
  input  lcmc_pkg::lcmc_ctrl_t       ctrl,
  input  logic [MAX_ENTRIES-1:0]     sel,
  input  logic [RW-1:0]              sel_rank,
  input  logic [CW-1:0]              count_next,
  output logic [lcmc_pkg::KEY_W-1:0] keys [MAX_ENTRIES],
  output logic [RW-1:0]              ranks [MAX_ENTRIES],
  output logic [CW-1:0]              count
);
  import lcmc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        ranks[i] <= '0;
      end
    end else if (item_valid) begin
      count <= count_next;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (sel[i]) begin
          ranks[i] <= '0;
        end else if ((CW'(i) < count) && (ctrl.insert || (ranks[i] < sel_rank))) begin
          ranks[i] <= ranks[i] + RW'(1);
        end
      end
    end
  end

  // key storage, no reset: only occupied entries are ever read
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (item_valid && !ctrl.hit && sel[i]) begin
        keys[i] <= key;
      end
    end
  end

endmodule

>>> rtl/lru_cache_miss_counter_top.sv
// Result path: an accepted item is registered into in_valid and in_key, is looked
//   up, and its result is registered onto the result ports with done high.
// Throughput: one item per cycle while busy is low; the parallel tag compare
//   and rank update between the input register and the state registers set this.
// Reset (rst, synchronous): empties the cache, clears the miss total, sets the
//   capacity to 16; busy stays high until the first clock edge after rst falls.
module lru_cache_miss_counter_top #(
  parameter int MAX_ENTRIES = lcmc_pkg::MAX_ENTRIES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [lcmc_pkg::KEY_W-1:0] access_key,
  input  logic                              cfg_write,
  input  logic [lcmc_pkg::CAP_W-1:0]        cfg_data,
  output logic                              done,
  output logic                              hit,
  output logic                              evicted_valid,
  output logic signed [lcmc_pkg::KEY_W-1:0] evicted_key,
  output logic [lcmc_pkg::MISS_W-1:0]       miss_count,
  output logic [lcmc_pkg::OCC_W-1:0]        occupancy
);
  import lcmc_pkg::*;
  `include "lru_cache_miss_counter_top_assert.svh"

  localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic             in_valid;
  logic [KEY_W-1:0] in_key;
  logic [CAP_W-1:0] capacity;
  logic [MISS_W-1:0] miss_total;
  logic [MISS_W-1:0] miss_total_next;

  logic [KEY_W-1:0] keys [MAX_ENTRIES];
  logic [RW-1:0]    ranks [MAX_ENTRIES];
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  lcmc_ctrl_t       ctrl;
  logic [MAX_ENTRIES-1:0] sel;
  logic [RW-1:0]    sel_rank;
  logic [KEY_W-1:0] ev_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      in_valid <= 1'b0;
      capacity <= CAP_RESET;
    end else begin
      busy <= 1'b0;
      in_valid <= start && !busy;
      if (cfg_write) begin
        capacity <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_key <= access_key;
    end
  end

  lcmc_lookup #(.MAX_ENTRIES(MAX_ENTRIES), .RW(RW), .CW(CW)) u_lookup (
    .key        (in_key),
    .keys       (keys),
    .ranks      (ranks),
    .count      (count),
    .capacity   (capacity),
    .ctrl       (ctrl),
    .sel        (sel),
    .sel_rank   (sel_rank),
    .evicted_key(ev_key),
    .count_next (count_next)
  );

  lcmc_store #(.MAX_ENTRIES(MAX_ENTRIES), .RW(RW), .CW(CW)) u_store (
    .clk       (clk),
    .rst       (rst),
    .item_valid(in_valid),
    .key       (in_key),
    .ctrl      (ctrl),
    .sel       (sel),
    .sel_rank  (sel_rank),
    .count_next(count_next),
    .keys      (keys),
    .ranks     (ranks),
    .count     (count)
  );

  always_comb begin
    miss_total_next = miss_total;
    if (!ctrl.hit && (miss_total != {MISS_W{1'b1}})) begin
      miss_total_next = miss_total + MISS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      miss_total <= '0;
    end else begin
      done <= in_valid;
      if (in_valid) begin
        miss_total <= miss_total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      hit <= ctrl.hit;
      evicted_valid <= ctrl.evict;
      evicted_key <= ev_key;
      occupancy <= OCC_W'(count_next);
    end
  end

  assign miss_count = miss_total;

  `LCMC_ASSERT_NEXT(a_result_follows, clk, rst, in_valid, done)
  `LCMC_ASSERT_NOW(a_hit_no_evict, clk, rst, done, !(hit && evicted_valid))
  `LCMC_ASSERT_NOW(a_evkey_zero, clk, rst, done && !evicted_valid, evicted_key == '0)
  `LCMC_ASSERT_NOW(a_lookup_onehot, clk, rst, in_valid, $onehot(sel))

endmodule

>>> bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lcmc_pkg::*;

  localparam int NUM_ENTRIES = MAX_ENTRIES_DEFAULT;
  localparam int RANDOM_ITEMS = 700;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 4;

  typedef enum logic [1:0] {OP_ACCESS, OP_SETCAP, OP_DRAIN} op_kind_t;

  typedef struct {
    op_kind_t         kind;
    logic [KEY_W-1:0] key;
    logic [CAP_W-1:0] cap;
  } cache_op_t;

  typedef struct {
    logic              hit;
    logic              ev_valid;
    logic [KEY_W-1:0]  ev_key;
    logic [MISS_W-1:0] misses;
    logic [OCC_W-1:0]  occ;
  } access_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [KEY_W-1:0] access_key = '0;
  logic                    cfg_write = 1'b0;
  logic [CAP_W-1:0]        cfg_data = '0;
  logic                    done;
  logic                    hit;
  logic                    evicted_valid;
  logic signed [KEY_W-1:0] evicted_key;
  logic [MISS_W-1:0]       miss_count;
  logic [OCC_W-1:0]        occupancy;

  lru_cache_miss_counter_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .access_key   (access_key),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .done         (done),
    .hit          (hit),
    .evicted_valid(evicted_valid),
    .evicted_key  (evicted_key),
    .miss_count   (miss_count),
    .occupancy    (occupancy)
  );

  always #6 clk = ~clk;

  // shadow copy of the cache
  logic [KEY_W-1:0]  tag_mem [NUM_ENTRIES];
  int unsigned       age_mem [NUM_ENTRIES];
  int unsigned       used_cnt = 0;
  logic [MISS_W-1:0] miss_tot = '0;
  logic [CAP_W-1:0]  cap_reg = CAP_RESET;

  cache_op_t      pending_ops[$];
  access_result_t expected_results[$];
  int             errors = 0;
  int             accepted_items = 0;
  int             stall_cycles = 0;
  int             settle_cnt = 0;

  function automatic void age_younger(int unsigned limit);
    for (int i = 0; i < used_cnt; i++) begin
      if (age_mem[i] < limit) age_mem[i]++;
    end
  endfunction

  function automatic access_result_t lookup_and_update(logic [KEY_W-1:0] key);
    access_result_t res;
    int unsigned    cap;
    int unsigned    idx;
    int unsigned    victim;
    logic           found;
    cap = cap_reg;
    if (cap == 0) cap = 1;
    if (cap > NUM_ENTRIES) cap = NUM_ENTRIES;
    found = 1'b0;
    idx = 0;
    res.ev_valid = 1'b0;
    res.ev_key = '0;
    for (int i = 0; i < used_cnt; i++) begin
      if (!found && tag_mem[i] == key) begin
        found = 1'b1;
        idx = i;
      end
    end
    if (found) begin
      age_younger(age_mem[idx]);
      age_mem[idx] = 0;
    end else begin
      if (miss_tot != '1) miss_tot++;
      if (used_cnt >= cap) begin
        victim = 0;
        for (int i = 1; i < used_cnt; i++) begin
          if (age_mem[i] > age_mem[victim]) victim = i;
        end
        res.ev_valid = 1'b1;
        res.ev_key = tag_mem[victim];
        age_younger(age_mem[victim]);
        tag_mem[victim] = key;
        age_mem[victim] = 0;
      end else begin
        age_younger(32'hFFFF_FFFF);
        tag_mem[used_cnt] = key;
        age_mem[used_cnt] = 0;
        used_cnt++;
      end
    end
    res.hit = found;
    res.misses = miss_tot;
    res.occ = used_cnt[OCC_W-1:0];
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t mismatch %s expected %h actual %h", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  task automatic push_access(logic [KEY_W-1:0] key);
    cache_op_t op;
    op.kind = OP_ACCESS;
    op.key = key;
    op.cap = '0;
    pending_ops.push_back(op);
  endtask

  task automatic push_setcap(logic [CAP_W-1:0] cap);
    cache_op_t op;
    op.kind = OP_DRAIN;
    op.key = '0;
    op.cap = '0;
    pending_ops.push_back(op);
    op.kind = OP_SETCAP;
    op.cap = cap;
    pending_ops.push_back(op);
  endtask

  task automatic push_drain();
    cache_op_t op;
    op.kind = OP_DRAIN;
    op.key = '0;
    op.cap = '0;
    pending_ops.push_back(op);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst || pending_ops.size() == 0) begin
      start <= 1'b0;
      cfg_write <= 1'b0;
    end else begin
      case (pending_ops[0].kind)
        OP_ACCESS: begin
          cfg_write <= 1'b0;
          access_key <= pending_ops[0].key;
          if (accepted_items >= 300 && accepted_items < 450) begin
            start <= 1'b1;
          end else begin
            start <= ($urandom_range(0, 99) >= 13);
          end
        end
        OP_SETCAP: begin
          start <= 1'b0;
          cfg_write <= 1'b1;
          cfg_data <= pending_ops[0].cap;
        end
        default: begin
          start <= 1'b0;
          cfg_write <= 1'b0;
          if (expected_results.size() == 0) begin
            settle_cnt++;
            if (settle_cnt >= SETTLE_CYCLES) begin
              settle_cnt = 0;
              void'(pending_ops.pop_front());
            end
          end
        end
      endcase
    end
  end

  // monitor, predictor update and watchdog
  always @(posedge clk) begin
    access_result_t exp_res;
    logic           progress;
    if (!rst) begin
      progress = 1'b0;
      if (done) begin
        progress = 1'b1;
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result: hit %b evicted %b key %h misses %h occupancy %0d",
                   $time, hit, evicted_valid, evicted_key, miss_count, occupancy);
          errors++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("hit", exp_res.hit, hit);
          check_field("evicted_valid", exp_res.ev_valid, evicted_valid);
          check_field("evicted_key", exp_res.ev_key, evicted_key);
          check_field("miss_count", exp_res.misses, miss_count);
          check_field("occupancy", exp_res.occ, occupancy);
        end
      end
      if (start && !busy) begin
        progress = 1'b1;
        expected_results.push_back(lookup_and_update(access_key));
        void'(pending_ops.pop_front());
        accepted_items++;
      end
      if (cfg_write) begin
        progress = 1'b1;
        cap_reg = cfg_data;
        void'(pending_ops.pop_front());
      end
      if (progress) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("FAIL lru_cache_miss_counter_top");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [KEY_W-1:0] pool [32];
    logic [CAP_W-1:0] cap;
    int               n_items;
    int               eff;
    int               pool_n;
    int               len;

    // directed: extreme keys, a hit at the oldest entry and one at the second newest
    push_access(32'h0000_0000);
    push_access(32'hFFFF_FFFF);
    push_access(32'h8000_0000);
    push_access(32'h7FFF_FFFF);
    push_access(32'h0000_0000);
    push_access(32'h7FFF_FFFF);
    push_access(32'h5555_5555);
    push_access(32'hAAAA_AAAA);
    // capacity below occupancy: occupancy holds, misses evict
    push_setcap(5'd2);
    push_access(32'h0000_0001);
    push_access(32'h0000_0002);
    push_access(32'h8000_0000);
    push_access(32'h0000_0003);
    // capacity zero acts as one
    push_setcap(5'd0);
    push_access(32'h0000_0005);
    push_access(32'h0000_0005);
    push_access(32'h0000_0006);
    push_access(32'h0000_0007);
    // capacity above the entry count saturates
    push_setcap(5'd31);
    push_access(32'h0000_0008);
    push_access(32'h0000_0009);
    push_access(32'hFFFF_FFFF);

    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: cap = 5'd1;
        1: cap = 5'd16;
        2: cap = 5'd31;
        3: cap = 5'd0;
        default: cap = CAP_W'($urandom_range(0, 31));
      endcase
      push_setcap(cap);
      eff = (cap == 0) ? 1 : ((cap > NUM_ENTRIES) ? NUM_ENTRIES : cap);
      pool_n = eff + $urandom_range(0, 5);
      for (int i = 0; i < pool_n; i++) pool[i] = $urandom;
      len = $urandom_range(25, 70);
      for (int j = 0; j < len; j++) begin
        if (j > 0 && $urandom_range(0, 99) < 3) push_drain();
        if ($urandom_range(0, 99) < 85) begin
          push_access(pool[$urandom_range(0, pool_n - 1)]);
        end else begin
          push_access($urandom);
        end
        n_items++;
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS lru_cache_miss_counter_top");
    end else begin
      $display("FAIL lru_cache_miss_counter_top");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/lcmc_pkg.sv
rtl/lcmc_lookup.sv
rtl/lcmc_store.sv
rtl/lru_cache_miss_counter_top.sv
bench/testbench.sv
